FILE: hw/rtl/swhn_pkg.sv
// Shared constants, register indexes and helpers for the sine wave height and normal block.
`timescale 1ns / 1ps
`default_nettype none
package swhn_pkg;

   localparam int ATAN_STEPS = 24;
   localparam int CSR_IDX_W  = 3;

   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic [31:0]        EIGHTH_TURN     = 32'h2000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AMPLITUDE    = 3'd0,
      CSR_SPATIAL_RATE = 3'd1,
      CSR_TIME_RATE    = 3'd2,
      CSR_DIR_X        = 3'd3,
      CSR_DIR_Z        = 3'd4,
      CSR_SLOPE_GAIN   = 3'd5
   } csr_idx_type;

   // Arctangent of 2^-i in Q0.32 turns.
   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] r;
      case (i)
         0:       r = 32'd536870912;
         1:       r = 32'd316933406;
         2:       r = 32'd167458907;
         3:       r = 32'd85004756;
         4:       r = 32'd42667331;
         5:       r = 32'd21354465;
         6:       r = 32'd10679838;
         7:       r = 32'd5340245;
         8:       r = 32'd2670163;
         9:       r = 32'd1335087;
         10:      r = 32'd667544;
         11:      r = 32'd333772;
         12:      r = 32'd166886;
         13:      r = 32'd83443;
         14:      r = 32'd41722;
         15:      r = 32'd20861;
         16:      r = 32'd10430;
         17:      r = 32'd5215;
         18:      r = 32'd2608;
         19:      r = 32'd1304;
         20:      r = 32'd652;
         21:      r = 32'd326;
         22:      r = 32'd163;
         23:      r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   // Round half up from Q.30 and clamp to signed 32 bits.
   function automatic logic [31:0] rnd_sat30(input logic signed [67:0] v);
      logic signed [67:0] r;
      logic [31:0]        o;
      r = (v + 68'sd536870912) >>> 30;
      if (r > 68'sd2147483647)
         o = 32'h7FFF_FFFF;
      else if (r < -68'sd2147483648)
         o = 32'h8000_0000;
      else
         o = r[31:0];
      return o;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/sine_wave_height_normal_top.sv
// Pipelined directional sine wave: height, slopes and unit normal per surface point.
//
// Usage: req_ beats carry one surface point (pos_x, pos_z, time_req); each
// produces exactly one rsp_ beat with height, slope_x, slope_z and the unit
// normal. The csr_ channel writes the six wave registers by index; it is
// always ready and should only be written while no beats are in flight.
// Throughput: one beat per cycle while rsp_tready or an empty output slot
// lets the pipeline advance. The pipeline has one register stage per CORDIC
// step (iterations capped at 24), 32 stages of the bit-serial square root
// and 15 stages of each normal divider, plus the multiplier stages around them.
// Reset: synchronous, active high; clears all in-flight valid bits and loads
// the register defaults (amplitude 1.0, rates 1.0, direction +x, gain 1.0).
// Backpressure: when rsp_tvalid is high and rsp_tready is low, the whole
// pipeline holds and req_tready drops; nothing is lost or repeated. An empty
// output slot lets the pipeline advance regardless of rsp_tready.
`timescale 1ns / 1ps
`default_nettype none
module sine_wave_height_normal_top #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output      logic                           req_tready,
   input  wire logic [95:0]                    req_tdata,  // pos_x, pos_z, time_req
   output      logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   // height, slope_x, slope_z, normal_x, normal_y, normal_z
   output      logic [143:0]                   rsp_tdata,
   input  wire logic                           csr_valid,
   output      logic                           csr_ready,
   input  wire logic [swhn_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_data
);
   import swhn_pkg::*;

   localparam int NIT = (TRIG_ITERATIONS < ATAN_STEPS) ? TRIG_ITERATIONS : ATAN_STEPS;
   localparam int LAT = NIT + 59;
   localparam int SQ_STEPS = 32;
   localparam int DV_STEPS = 15;

   // configuration
   logic [30:0]        amp_ff, sg_ff;
   logic [31:0]        sr_ff, tr_ff;
   logic signed [15:0] dir_x_ff, dir_z_ff;
   logic signed [47:0] gxp_in, gzp_in;
   logic signed [33:0] gx_ff, gz_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff   <= 31'd65536;
         sr_ff    <= 32'd65536;
         tr_ff    <= 32'd65536;
         dir_x_ff <= 16'sd16384;
         dir_z_ff <= 16'sd0;
         sg_ff    <= 31'd65536;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_AMPLITUDE:    amp_ff   <= csr_data[30:0];
            CSR_SPATIAL_RATE: sr_ff    <= csr_data;
            CSR_TIME_RATE:    tr_ff    <= csr_data;
            CSR_DIR_X:        dir_x_ff <= csr_data[15:0];
            CSR_DIR_Z:        dir_z_ff <= csr_data[15:0];
            CSR_SLOPE_GAIN:   sg_ff    <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // slope gain per axis, Q16.16 with round half up
   assign gxp_in = $signed({1'b0, sg_ff}) * dir_x_ff;
   assign gzp_in = $signed({1'b0, sg_ff}) * dir_z_ff;

   always_ff @(posedge clock) begin
      gx_ff <= 34'((gxp_in + 48'sd8192) >>> 14);
      gz_ff <= 34'((gzp_in + 48'sd8192) >>> 14);
   end

   // pipeline control
   logic [LAT-1:0] vld_ff;
   logic           adv;

   assign adv        = ~vld_ff[LAT-1] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else if (adv)
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
   end

   // phase
   logic signed [31:0] px, pz;
   logic [31:0]        t;
   logic [63:0]        tprod;
   logic signed [47:0] dx_ff, dz_ff;
   logic [31:0]        tp1_ff, tp2_ff, tp3_ff;
   logic signed [48:0] dot_ff;
   logic [54:0]        pl_ff, phx;
   logic [22:0]        ph_ff;
   logic [45:0]        spat;
   logic [31:0]        phase_ff, u;

   assign px    = req_tdata[31:0];
   assign pz    = req_tdata[63:32];
   assign t     = req_tdata[95:64];
   assign tprod = t * tr_ff;
   assign phx   = dot_ff[45:23] * sr_ff;
   assign spat  = pl_ff[45:0] + {ph_ff, 23'b0};
   assign u     = phase_ff + EIGHTH_TURN;

   // CORDIC arrays: index i is the input of step i
   logic signed [33:0] cx_ff [0:NIT];
   logic signed [33:0] cy_ff [0:NIT];
   logic signed [33:0] cz_ff [0:NIT];
   logic [1:0]         cq_ff [0:NIT];

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff    <= dir_x_ff * px;
         dz_ff    <= dir_z_ff * pz;
         tp1_ff   <= tprod[31:0];
         dot_ff   <= {dx_ff[47], dx_ff} + {dz_ff[47], dz_ff};
         tp2_ff   <= tp1_ff;
         pl_ff    <= dot_ff[22:0] * sr_ff;
         ph_ff    <= phx[22:0];
         tp3_ff   <= tp2_ff;
         phase_ff <= spat[45:14] + tp3_ff;
         cx_ff[0] <= CORDIC_GAIN_Q30;
         cy_ff[0] <= '0;
         cz_ff[0] <= $signed({4'b0, u[29:0]}) - 34'sd536870912;
         cq_ff[0] <= u[31:30];
      end
   end

   for (genvar i = 0; i < NIT; i++) begin : g_cordic
      logic signed [33:0] atn;
      assign atn = $signed({2'b0, atan_turn(i)});
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!cz_ff[i][33]) begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - atn;
            end else begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + atn;
            end
            cq_ff[i+1] <= cq_ff[i];
         end
      end
   end

   // quadrant fold, products, rounding
   logic signed [33:0] sn_in, cs_in, sn_ff, cs_ff, xe, ye;
   logic signed [65:0] hp_ff;
   logic signed [67:0] xp_ff, zp_ff;
   logic [31:0]        h_ff, sx_ff, sz_ff;
   logic signed [63:0] sxx, szz;
   logic [63:0]        sxx_ff, szz_ff;
   logic [95:0]        car_sq_ff;

   assign xe = cx_ff[NIT];
   assign ye = cy_ff[NIT];

   always_comb begin
      case (cq_ff[NIT])
         2'd0:    begin cs_in = xe;  sn_in = ye;  end
         2'd1:    begin cs_in = -ye; sn_in = xe;  end
         2'd2:    begin cs_in = -xe; sn_in = -ye; end
         default: begin cs_in = ye;  sn_in = -xe; end
      endcase
   end

   assign sxx = $signed(sx_ff) * $signed(sx_ff);
   assign szz = $signed(sz_ff) * $signed(sz_ff);

   // square root arrays
   logic [63:0] sv_ff   [0:SQ_STEPS];
   logic [63:0] sres_ff [0:SQ_STEPS];
   logic [95:0] scar_ff [0:SQ_STEPS];

   always_ff @(posedge clock) begin
      if (adv) begin
         sn_ff      <= sn_in;
         cs_ff      <= cs_in;
         hp_ff      <= $signed({1'b0, amp_ff}) * sn_ff;
         xp_ff      <= gx_ff * cs_ff;
         zp_ff      <= gz_ff * cs_ff;
         h_ff       <= rnd_sat30({{2{hp_ff[65]}}, hp_ff});
         sx_ff      <= rnd_sat30(xp_ff);
         sz_ff      <= rnd_sat30(zp_ff);
         sxx_ff     <= sxx;
         szz_ff     <= szz;
         car_sq_ff  <= {sz_ff, sx_ff, h_ff};
         sv_ff[0]   <= sxx_ff + szz_ff + 64'h1_0000_0000;
         sres_ff[0] <= '0;
         scar_ff[0] <= car_sq_ff;
      end
   end

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
      logic [64:0] trial;
      assign trial = {1'b0, sres_ff[j]} + {1'b0, BIT};
      always_ff @(posedge clock) begin
         if (adv) begin
            if ({1'b0, sv_ff[j]} >= trial) begin
               sv_ff[j+1]   <= sv_ff[j] - trial[63:0];
               sres_ff[j+1] <= (sres_ff[j] >> 1) + BIT;
            end else begin
               sv_ff[j+1]   <= sv_ff[j];
               sres_ff[j+1] <= sres_ff[j] >> 1;
            end
            scar_ff[j+1] <= scar_ff[j];
         end
      end
   end

   // normal dividers: lane 0 x, lane 1 y, lane 2 z
   logic [32:0] len;
   logic [31:0] sxf, szf, magx, magz;
   logic [47:0] dr_ff  [0:2][0:DV_STEPS];
   logic [14:0] dq_ff  [0:2][0:DV_STEPS];
   logic [1:0]  dn_ff  [0:DV_STEPS];
   logic [32:0] dl_ff  [0:DV_STEPS];
   logic [95:0] dcar_ff [0:DV_STEPS];

   assign len  = sres_ff[SQ_STEPS][32:0];
   assign sxf  = scar_ff[SQ_STEPS][63:32];
   assign szf  = scar_ff[SQ_STEPS][95:64];
   assign magx = sxf[31] ? (~sxf + 32'd1) : sxf;
   assign magz = szf[31] ? (~szf + 32'd1) : szf;

   always_ff @(posedge clock) begin
      if (adv) begin
         dr_ff[0][0] <= {2'b0, magx, 14'b0} + {16'b0, len[32:1]};
         dr_ff[1][0] <= {2'b0, 32'd65536, 14'b0} + {16'b0, len[32:1]};
         dr_ff[2][0] <= {2'b0, magz, 14'b0} + {16'b0, len[32:1]};
         dq_ff[0][0] <= '0;
         dq_ff[1][0] <= '0;
         dq_ff[2][0] <= '0;
         // component negative when slope positive
         dn_ff[0]    <= {~szf[31] & (szf != 32'd0), ~sxf[31] & (sxf != 32'd0)};
         dl_ff[0]    <= len;
         dcar_ff[0]  <= scar_ff[SQ_STEPS];
      end
   end

   for (genvar m = 0; m < DV_STEPS; m++) begin : g_div
      logic [47:0] dsh;
      assign dsh = {15'b0, dl_ff[m]} << (DV_STEPS - 1 - m);
      for (genvar l = 0; l < 3; l++) begin : g_lane
         always_ff @(posedge clock) begin
            if (adv) begin
               if (dr_ff[l][m] >= dsh) begin
                  dr_ff[l][m+1] <= dr_ff[l][m] - dsh;
                  dq_ff[l][m+1] <= dq_ff[l][m] | (15'd1 << (DV_STEPS - 1 - m));
               end else begin
                  dr_ff[l][m+1] <= dr_ff[l][m];
                  dq_ff[l][m+1] <= dq_ff[l][m];
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dn_ff[m+1]   <= dn_ff[m];
            dl_ff[m+1]   <= dl_ff[m];
            dcar_ff[m+1] <= dcar_ff[m];
         end
      end
   end

   // output register
   logic [15:0] nx, nz;
   logic [143:0] out_ff;

   assign nx = dn_ff[DV_STEPS][0] ? (~{1'b0, dq_ff[0][DV_STEPS]} + 16'd1)
                                  : {1'b0, dq_ff[0][DV_STEPS]};
   assign nz = dn_ff[DV_STEPS][1] ? (~{1'b0, dq_ff[2][DV_STEPS]} + 16'd1)
                                  : {1'b0, dq_ff[2][DV_STEPS]};

   always_ff @(posedge clock) begin
      if (adv)
         out_ff <= {nz, 1'b0, dq_ff[1][DV_STEPS], nx, dcar_ff[DV_STEPS]};
   end

   assign rsp_tdata = out_ff;

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench for the sine wave height and normal block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import swhn_pkg::*;

   localparam int TRIG_STEPS = 16;
   localparam int DRAIN_CYCLES = TRIG_STEPS + 59 + 40;
   localparam csr_idx_type CSR_SPARE = csr_idx_type'(3'd6);

   typedef struct {
      longint fld[6];
   } wave_point_type;

   typedef struct {
      logic [31:0] pos_x;
      logic [31:0] pos_z;
      logic [31:0] t;
      bit          zero_wave;
   } stim_row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [143:0] rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]  csr_data = '0;

   // shadow copy of the wave registers
   logic [31:0]        amp_q, space_q, tempo_q, gain_q;
   logic signed [15:0] dirx_q, dirz_q;

   wave_point_type wave_q[$];
   bit          failed = 0;
   bit          quiet = 0;
   int          ready_hold = 0;

   longint atan_tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
   string fld_name[6] = '{"height", "slope_x", "slope_z", "normal_x", "normal_y",
      "normal_z"};

   sine_wave_height_normal_top #(.TRIG_ITERATIONS(TRIG_STEPS)) dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   function automatic longint rnd30(longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint root_floor(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   function automatic longint unit_part(longint c, longint len);
      longint mag, q;
      mag = (c < 0) ? -c : c;
      q = ((mag << 14) + (len >> 1)) / len;
      return (c < 0) ? -q : q;
   endfunction

   function automatic wave_point_type wave_eval(logic [31:0] px, logic [31:0] pz,
                                                logic [31:0] t);
      wave_point_type r;
      longint dot, prod, x, y, z, nx, s, c, gx, gz, sx, sz, len;
      logic [63:0] tp, lsq;
      logic [31:0] phase, u;
      dot = longint'(dirx_q) * longint'(signed'(px)) + longint'(dirz_q) * longint'(signed'(pz));
      prod = dot * longint'({32'd0, space_q});
      tp = {32'd0, t} * {32'd0, tempo_q};
      phase = prod[45:14] + tp[31:0];
      u = phase + EIGHTH_TURN;
      z = longint'({34'd0, u[29:0]}) - longint'(EIGHTH_TURN);
      x = 652032874;
      y = 0;
      for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_tbl[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_tbl[i];
         end
         x = nx;
      end
      case (u[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      gx = (longint'(gain_q) * longint'(dirx_q) + 8192) >>> 14;
      gz = (longint'(gain_q) * longint'(dirz_q) + 8192) >>> 14;
      sx = clamp32(rnd30(gx * c));
      sz = clamp32(rnd30(gz * c));
      lsq = 64'(sx * sx) + 64'(sz * sz) + (64'd1 << 32);
      len = root_floor(lsq);
      r.fld[0] = clamp32(rnd30(longint'(amp_q) * s));
      r.fld[1] = sx;
      r.fld[2] = sz;
      r.fld[3] = unit_part(-sx, len);
      r.fld[4] = unit_part(65536, len);
      r.fld[5] = unit_part(-sz, len);
      return r;
   endfunction

   // leave csr_valid high; the caller drops it after the last beat
   task automatic csr_write(csr_idx_type idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_AMPLITUDE:    amp_q = {1'b0, val[30:0]};
         CSR_SPATIAL_RATE: space_q = val;
         CSR_TIME_RATE:    tempo_q = val;
         CSR_DIR_X:        dirx_q = val[15:0];
         CSR_DIR_Z:        dirz_q = val[15:0];
         CSR_SLOPE_GAIN:   gain_q = {1'b0, val[30:0]};
         default: ;
      endcase
   endtask

   task automatic drain();
      while (wave_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_wave(logic [31:0] a, logic [31:0] sr, logic [31:0] tr,
                            logic [31:0] dx, logic [31:0] dz, logic [31:0] g);
      drain();
      csr_write(CSR_AMPLITUDE, a);
      csr_write(CSR_SPATIAL_RATE, sr);
      csr_write(CSR_TIME_RATE, tr);
      csr_write(CSR_DIR_X, dx);
      csr_write(CSR_DIR_Z, dz);
      csr_write(CSR_SLOPE_GAIN, g);
      csr_write(CSR_SPARE, $urandom);
      csr_valid <= 0;
   endtask

   // push one point; flat rows carry a typed expectation
   task automatic send_point(logic [31:0] px, logic [31:0] pz, logic [31:0] t,
                             bit flat);
      wave_point_type e;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {t, pz, px};
      e = wave_eval(px, pz, t);
      if (flat) e.fld = '{0, 0, 0, 0, 16384, 0};
      do @(posedge clock); while (!req_tready);
      wave_q.push_back(e);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      endcase
   endfunction

   // random stalls on the result side
   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_tready <= !reset;
      end else if (ready_hold > 0) begin
         ready_hold--;
         rsp_tready <= (ready_hold == 0);
      end else if ($urandom_range(0, 5) == 0) begin
         ready_hold = $urandom_range(1, 8);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      wave_point_type e;
      longint got[6];
      if (!reset && rsp_tvalid && rsp_tready) begin
         got[0] = longint'($signed(rsp_tdata[31:0]));
         got[1] = longint'($signed(rsp_tdata[63:32]));
         got[2] = longint'($signed(rsp_tdata[95:64]));
         got[3] = longint'($signed(rsp_tdata[111:96]));
         got[4] = longint'($signed(rsp_tdata[127:112]));
         got[5] = longint'($signed(rsp_tdata[143:128]));
         if (wave_q.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, rsp_tdata);
            failed = 1;
         end else begin
            e = wave_q.pop_front();
            for (int k = 0; k < 6; k++)
               if (e.fld[k] != got[k]) begin
                  $display("%0t: %s expected %0d actual %0d", $time, fld_name[k],
                           e.fld[k], got[k]);
                  failed = 1;
               end
         end
      end
   end

   stim_row_type dir_rows[] = '{
      '{32'h0, 32'h0, 32'h0, 0},
      '{32'h7FFF_FFFF, 32'h0, 32'h0, 0},
      '{32'h8000_0000, 32'h0, 32'h0, 0},
      '{32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0},
      '{32'h0, 32'h8000_0000, 32'h0, 0},
      '{32'h0000_4000, 32'h0, 32'h0, 0},       // quarter turn: sine peak
      '{32'h0000_8000, 32'h0, 32'h0, 0},
      '{32'h0000_C000, 32'h0, 32'h0, 0},
      '{32'h0000_2000, 32'h0, 32'h0, 0},       // eighth turn: quadrant seam
      '{32'h0001_0000, 32'h0, 32'h0003_0000, 0}, // whole turns drop out
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 0},
      '{32'h0, 32'h0, 32'h0000_4000, 0},
      '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 1},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1},
      '{32'h0, 32'h0, 32'h0, 1}
   };

   initial begin
      amp_q = 65536; space_q = 65536; tempo_q = 65536;
      dirx_q = 16384; dirz_q = 0; gain_q = 65536;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         if (dir_rows[r].zero_wave && gain_q != 0) begin
            // drop the held beat before the pipeline drains
            req_tvalid <= 0;
            load_wave(0, $urandom, $urandom, $urandom, $urandom, 0);
         end
         send_point(dir_rows[r].pos_x, dir_rows[r].pos_z, dir_rows[r].t,
                    dir_rows[r].zero_wave);
      end
      req_tvalid <= 0;

      // saturation corner, then ordinary and random settings
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: load_wave(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000,
                         32'h7FFF, 32'h7FFF_FFFF);
            1: load_wave(0, 0, 0, 0, 0, 0);
            2: load_wave(65536, 65536, 65536, 16384, 0, 65536);
            3: load_wave(32'h8000_0000, 32'h0000_1000, 32'h0000_0100, 32'hFFFF_C000,
                         32'h0000_4000, 32'h0003_0000);
            default: load_wave($urandom, $urandom_range(0, 1 << 18), $urandom,
                               $urandom, $urandom, $urandom_range(0, 1 << 22));
         endcase
         if (p == 7) quiet = 1;
         for (int n = 0; n < 220; n++)
            send_point(rand_pos(), rand_pos(), $urandom, 0);
         req_tvalid <= 0;
      end

      drain();
      if (!failed)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
